### src/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the C subset lexer
// Character classes, lexer modes, result kinds, token class codes and the
// small lookup functions used to classify source bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

   // Lexer mode
   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_LETTER = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_SYMBOL = 2'd3
   } lex_mode_type;

   // Character class of one source byte
   typedef enum logic [2:0] {
      CC_LETTER = 3'd0,
      CC_DIGIT  = 3'd1,
      CC_SPACE  = 3'd2,
      CC_SYM    = 3'd3,
      CC_BAD    = 3'd4
   } char_class_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_TOKEN = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Token class codes
   localparam logic [3:0] CLS_IDENT   = 4'd0;
   localparam logic [3:0] CLS_INTEGER = 4'd1;
   localparam logic [3:0] CLS_TYPE    = 4'd2;
   localparam logic [3:0] CLS_KEYWORD = 4'd3;
   localparam logic [3:0] CLS_SEMI    = 4'd4;
   localparam logic [3:0] CLS_LPAREN  = 4'd5;
   localparam logic [3:0] CLS_RPAREN  = 4'd6;
   localparam logic [3:0] CLS_LBRACE  = 4'd7;
   localparam logic [3:0] CLS_RBRACE  = 4'd8;
   localparam logic [3:0] CLS_EQUALS  = 4'd9;

   // Character codes
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // Keyword lengths
   localparam int         INT_LEN    = 3;
   localparam int         RET_LEN    = 6;

   // Symbol code, CLS_IDENT when the byte is no symbol
   function automatic logic [3:0] symbol_code(input logic [7:0] c);
      logic [3:0] code;
      case (c)
         CH_SEMI:   code = CLS_SEMI;
         CH_LPAREN: code = CLS_LPAREN;
         CH_RPAREN: code = CLS_RPAREN;
         CH_LBRACE: code = CLS_LBRACE;
         CH_RBRACE: code = CLS_RBRACE;
         CH_EQUALS: code = CLS_EQUALS;
         default:   code = CLS_IDENT;
      endcase
      return code;
   endfunction

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cc;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER) begin
         cc = CC_LETTER;
      end else if (c >= "0" && c <= "9") begin
         cc = CC_DIGIT;
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
         cc = CC_SPACE;
      end else if (symbol_code(c) != CLS_IDENT) begin
         cc = CC_SYM;
      end else begin
         cc = CC_BAD;
      end
      return cc;
   endfunction

   // Letters of "int"
   function automatic logic [7:0] int_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = "i";
         2'd1:    c = "n";
         2'd2:    c = "t";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Letters of "return"
   function automatic logic [7:0] ret_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "r";
         3'd1:    c = "e";
         3'd2:    c = "t";
         3'd3:    c = "u";
         3'd4:    c = "r";
         3'd5:    c = "n";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### src/csl_if.sv
// ----------------------------------------------------------------------------
// csl_if: word channels of the C subset lexer
// Byte channel into the lexer and result channel out of it, each with
// valid/ready handshake and a source and sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface csl_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_last;

   modport source (output valid, output ch, output is_last, input ready);
   modport sink   (input valid, input ch, input is_last, output ready);
endinterface

interface csl_rsp_if #(
   parameter int POS_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [3:0]          tok_class;
   logic [POS_BITS-1:0] line;
   logic [POS_BITS-1:0] column;
   logic [POS_BITS-1:0] length;
   logic                done_res;

   modport source (output valid, output kind, output tok_class, output line,
                   output column, output length, output done_res, input ready);
   modport sink   (input valid, input kind, input tok_class, input line,
                   input column, input length, input done_res, output ready);
endinterface

`default_nettype wire

### src/c_subset_lexer_unit.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_unit: streaming lexer for a small C subset
// Classifies one source byte per cycle while its byte channel is ready and emits
// token, error and end-of-source words through a four-entry result queue.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle and its results appear on the
// result channel from the next cycle on. Each byte is classified and folded
// into the lexer state in the cycle it is accepted; the zero to three result
// words it causes are written at once into a four-entry result queue. The
// byte channel is ready while that queue holds at most one word, so a stream
// where each byte causes at most one word runs at one byte per cycle while
// the result side is ready; a byte that causes two or three words (a token
// end together with an illegal byte or the end of source) stalls the byte
// channel while they drain. Identifiers spelled int and return come out as
// type and keyword; after an illegal byte the rest of the source is skipped
// until the byte flagged last, which always closes with an end marker and
// restarts the lexer. Line, column and length saturate at POS_BITS ones.
`default_nettype none

module c_subset_lexer_unit
   import csl_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   csl_byte_if.sink         req_chan,
   csl_rsp_if.source        rsp_chan
);

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] tok_class;
      pos_type    line;
      pos_type    column;
      pos_type    length;
      logic       done_res;
   } rsp_word_type;

   localparam int QDEPTH = 4;

   function automatic pos_type sat_inc(input pos_type v);
      return (&v) ? v : v + pos_type'(1);
   endfunction

   // Class of the pending token
   function automatic logic [3:0] token_class(input lex_mode_type m,
                                              input logic [3:0] sym,
                                              input pos_type len,
                                              input logic [1:0] kw);
      logic [3:0] cls;
      if (m == MODE_NUMBER) begin
         cls = CLS_INTEGER;
      end else if (m == MODE_SYMBOL) begin
         cls = sym;
      end else if (len == pos_type'(INT_LEN) && kw[0]) begin
         cls = CLS_TYPE;
      end else if (len == pos_type'(RET_LEN) && kw[1]) begin
         cls = CLS_KEYWORD;
      end else begin
         cls = CLS_IDENT;
      end
      return cls;
   endfunction

   // Lexer state
   lex_mode_type mode_ff,   mode_in;
   logic         failed_ff, failed_in;
   pos_type      line_ff,   line_in;
   pos_type      col_ff,    col_in;
   pos_type      start_ff,  start_in;
   pos_type      len_ff,    len_in;
   logic [3:0]   sym_ff,    sym_in;
   logic [1:0]   kw_ff,     kw_in;

   // Result queue
   rsp_word_type             queue_ff [QDEPTH];
   logic [1:0]               wr_ptr_ff, wr_ptr_in;
   logic [1:0]               rd_ptr_ff, rd_ptr_in;
   logic [2:0]               count_ff,  count_in;

   logic                     accept;
   logic                     pop;
   rsp_word_type             cand   [4];
   logic [3:0]               cand_vld;
   rsp_word_type             push_word [4];
   logic [2:0]               push_cnt;

   assign req_chan.ready = (count_ff <= 3'd1);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   // Per-byte lexer step
   always_comb begin
      pos_type        col_next;
      char_class_type cc;
      logic           keep_int;
      logic           keep_ret;

      mode_in   = mode_ff;
      failed_in = failed_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      sym_in    = sym_ff;
      kw_in     = kw_ff;
      cand_vld  = '0;

      col_next = sat_inc(col_ff);
      cc       = classify(req_chan.ch);
      keep_int = (len_ff < pos_type'(INT_LEN)) && (req_chan.ch == int_char(len_ff[1:0]));
      keep_ret = (len_ff < pos_type'(RET_LEN)) && (req_chan.ch == ret_char(len_ff[2:0]));

      // flush of the token ended by this byte
      cand[0] = '{kind: KIND_TOKEN,
                  tok_class: token_class(mode_ff, sym_ff, len_ff, kw_ff),
                  line: line_ff, column: start_ff, length: len_ff, done_res: 1'b0};
      // illegal byte
      cand[1] = '{kind: KIND_ERROR, tok_class: CLS_IDENT, line: line_ff,
                  column: col_next, length: '0, done_res: 1'b0};
      cand[2] = cand[0];
      // end marker
      cand[3] = '{kind: KIND_END, tok_class: CLS_IDENT, line: '0, column: '0,
                  length: '0, done_res: 1'b1};

      if (accept) begin
         if (!failed_ff) begin
            if (mode_ff == MODE_LETTER && (cc == CC_LETTER || cc == CC_DIGIT)) begin
               kw_in  = kw_ff & {keep_ret, keep_int};
               len_in = sat_inc(len_ff);
            end else if (mode_ff == MODE_NUMBER && cc == CC_DIGIT) begin
               len_in = sat_inc(len_ff);
            end else begin
               cand_vld[0] = (mode_ff != MODE_START);
               mode_in     = MODE_START;
               case (cc)
                  CC_LETTER: begin
                     mode_in  = MODE_LETTER;
                     kw_in    = {req_chan.ch == ret_char(3'd0),
                                 req_chan.ch == int_char(2'd0)};
                     start_in = col_next;
                     len_in   = pos_type'(1);
                  end
                  CC_DIGIT: begin
                     mode_in  = MODE_NUMBER;
                     start_in = col_next;
                     len_in   = pos_type'(1);
                  end
                  CC_SYM: begin
                     mode_in  = MODE_SYMBOL;
                     sym_in   = symbol_code(req_chan.ch);
                     start_in = col_next;
                     len_in   = pos_type'(1);
                  end
                  CC_BAD: begin
                     cand_vld[1] = 1'b1;
                     failed_in   = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end

            // position tracking
            if (req_chan.ch == CH_NEWLINE) begin
               line_in = sat_inc(line_ff);
               col_in  = '0;
            end else begin
               col_in  = col_next;
            end
         end

         // end of source: flush what is pending, mark the end, restart
         if (req_chan.is_last) begin
            cand[2] = '{kind: KIND_TOKEN,
                        tok_class: token_class(mode_in, sym_in, len_in, kw_in),
                        line: line_in, column: start_in, length: len_in,
                        done_res: 1'b0};
            cand_vld[2] = !failed_in && (mode_in != MODE_START);
            cand_vld[3] = 1'b1;
            mode_in   = MODE_START;
            failed_in = 1'b0;
            line_in   = pos_type'(1);
            col_in    = '0;
            start_in  = pos_type'(1);
            len_in    = '0;
            sym_in    = CLS_IDENT;
            kw_in     = 2'b11;
         end
      end
   end

   // Pack valid candidates in order
   always_comb begin
      logic [2:0] n;
      n = '0;
      for (int i = 0; i < 4; i++) begin
         push_word[i] = cand[3];
      end
      for (int i = 0; i < 4; i++) begin
         if (cand_vld[i]) begin
            push_word[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      push_cnt = n;
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + push_cnt - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_START;
         failed_ff <= 1'b0;
         line_ff   <= pos_type'(1);
         col_ff    <= '0;
         start_ff  <= pos_type'(1);
         len_ff    <= '0;
         sym_ff    <= CLS_IDENT;
         kw_ff     <= 2'b11;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         failed_ff <= failed_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         sym_ff    <= sym_in;
         kw_ff     <= kw_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         if (3'(i) < push_cnt) begin
            queue_ff[wr_ptr_ff + 2'(i)] <= push_word[i];
         end
      end
   end

   // Result channel
   assign rsp_chan.valid     = (count_ff != 3'd0);
   assign rsp_chan.kind      = queue_ff[rd_ptr_ff].kind;
   assign rsp_chan.tok_class = queue_ff[rd_ptr_ff].tok_class;
   assign rsp_chan.line      = queue_ff[rd_ptr_ff].line;
   assign rsp_chan.column    = queue_ff[rd_ptr_ff].column;
   assign rsp_chan.length    = queue_ff[rd_ptr_ff].length;
   assign rsp_chan.done_res  = queue_ff[rd_ptr_ff].done_res;

endmodule

`default_nettype wire
